### src/cyclic_handler_timer_table_defines.svh
// assertion macros for the checker file
`ifndef CYCLIC_HANDLER_TIMER_TABLE_DEFINES_SVH
`define CYCLIC_HANDLER_TIMER_TABLE_DEFINES_SVH

`define CHT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define CHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/cht_pkg.sv
package cht_pkg;

   localparam logic [2:0] REQ_CREATE     = 3'd0;
   localparam logic [2:0] REQ_CREATE_ANY = 3'd1;
   localparam logic [2:0] REQ_DELETE     = 3'd2;
   localparam logic [2:0] REQ_START      = 3'd3;
   localparam logic [2:0] REQ_STOP       = 3'd4;
   localparam logic [2:0] REQ_QUERY      = 3'd5;
   localparam logic [2:0] REQ_TICK       = 3'd6;
   localparam logic [2:0] REQ_BAD        = 3'd7;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_ID    = 3'd1;
   localparam logic [2:0] ST_EXISTS    = 3'd2;
   localparam logic [2:0] ST_BAD_PARAM = 3'd3;
   localparam logic [2:0] ST_NO_ID     = 3'd4;
   localparam logic [2:0] ST_NOT_EXIST = 3'd5;

   localparam int MAX_RESULTS = 16;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [4:0]  channel_id;
      logic        attr_start;
      logic [30:0] period;
      logic [30:0] phase;
      logic [31:0] handler_arg;
      logic [15:0] tick_delta;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  channel_out;
      logic        running;
      logic [32:0] time_left;
      logic        fire_valid;
      logic [31:0] fire_arg;
      logic        last;
   } rsp_type;

endpackage

### src/cht_ram.sv
module cht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/cht_front.sv
module cht_front #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  cht_pkg::req_type_type in_req,
   output logic                  out_valid,
   input  logic                  out_take,
   output cht_pkg::req_type_type out_req
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cht_pkg::req_type_type q_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_stall  = (cnt_ff == (AW+1)'(DEPTH));
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_take;
   assign out_req   = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= in_req;
      end
   end
endmodule

### src/cht_back.sv
module cht_back #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_take,
   input  cht_pkg::req_type_type in_req,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cht_pkg::rsp_type      rsp
);
   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DW = 32 + 32 + 32 + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_SWAIT = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;
   localparam logic [2:0] S_EWAIT = 3'd6;

   logic [2:0] state_ff, state_in;
   cht_pkg::req_type_type req_ff, req_in;
   logic [NUM_CHANNELS-1:0] act_ff, act_in, run_ff, run_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [4:0]    nfire_ff, nfire_in;
   cht_pkg::rsp_type rsp_ff, rsp_in;
   logic          rv_ff, rv_in;
   // result waiting for the output register; a fire is held back until the next fire or the end of the scan
   logic          hold_ff, hold_in;
   cht_pkg::rsp_type hold_rsp_ff, hold_rsp_in;

   // entry word: attr, count, reload, phase; arg separate
   logic          wr_en;
   logic [CW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data, rd_data;
   logic [31:0]   arg_rd;
   logic          arg_wr;
   logic [31:0]   arg_wdata;

   logic               e_attr;
   logic signed [31:0] e_count, e_reload, e_phase, n_count, n_phase;
   logic [4:0]         id;
   logic [CW-1:0]      slot;
   logic               id_ok;
   logic [CW-1:0]      free_idx;
   logic               free_any;

   cht_ram #(.WIDTH(DW), .DEPTH(NUM_CHANNELS)) u_ent (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   cht_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_arg (
      .clock(clock), .wr_en(arg_wr), .wr_addr(wr_addr), .wr_data(arg_wdata),
      .rd_addr(rd_addr), .rd_data(arg_rd));

   assign e_attr   = rd_data[96];
   assign e_count  = rd_data[95:64];
   assign e_reload = rd_data[63:32];
   assign e_phase  = rd_data[31:0];

   assign id    = req_ff.channel_id;
   assign id_ok = (id >= 5'd1) && ({1'b0, id} <= 6'(NUM_CHANNELS));
   assign slot  = CW'(id - 5'd1);

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_any = 1'b1;
            free_idx = CW'(i);
         end
      end
   end

   assign rd_addr = (state_ff == S_IDLE) ? '0 : idx_ff;
   assign in_take = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp = rsp_ff;

   always_comb begin
      n_phase = e_phase;
      n_count = e_count;
      if (e_phase > 0) begin
         n_phase = e_phase - $signed({16'd0, req_ff.tick_delta});
      end else begin
         n_phase = '0;
         n_count = e_count - $signed({16'd0, req_ff.tick_delta});
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      act_in      = act_ff;
      run_in      = run_ff;
      idx_in      = idx_ff;
      nfire_in    = nfire_ff;
      rsp_in      = rsp_ff;
      rv_in       = rv_ff;
      hold_in     = hold_ff;
      hold_rsp_in = hold_rsp_ff;
      wr_en       = 1'b0;
      arg_wr      = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = rd_data;
      arg_wdata   = req_ff.handler_arg;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               req_in   = in_req;
               idx_in   = '0;
               nfire_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (req_ff.req_type == cht_pkg::REQ_TICK) begin
               idx_in   = '0;
               state_in = S_SWAIT;
            end else begin
               if (req_ff.req_type == cht_pkg::REQ_CREATE_ANY) begin
                  idx_in = free_idx;
               end else begin
                  idx_in = slot;
               end
               state_in = S_EWAIT;
            end
         end
         S_EWAIT: begin
            state_in = S_EXEC;
         end
         S_SWAIT: begin
            state_in = S_SCAN;
         end
         S_EXEC: begin
            hold_rsp_in = '0;
            hold_in     = 1'b1;
            wr_addr = idx_ff;
            case (req_ff.req_type) inside
               cht_pkg::REQ_CREATE, cht_pkg::REQ_CREATE_ANY: begin
                  if (req_ff.req_type == cht_pkg::REQ_CREATE_ANY && !free_any) begin
                     hold_rsp_in.status = cht_pkg::ST_NO_ID;
                  end else if (req_ff.req_type == cht_pkg::REQ_CREATE && !id_ok) begin
                     hold_rsp_in.status = cht_pkg::ST_BAD_ID;
                  end else if (req_ff.req_type == cht_pkg::REQ_CREATE && act_ff[idx_ff]) begin
                     hold_rsp_in.status = cht_pkg::ST_EXISTS;
                  end else if (req_ff.period == '0) begin
                     hold_rsp_in.status = cht_pkg::ST_BAD_PARAM;
                  end else begin
                     wr_en   = 1'b1;
                     arg_wr  = 1'b1;
                     wr_data = {req_ff.attr_start, 1'b0, req_ff.period,
                                1'b0, req_ff.period, 1'b0, req_ff.phase};
                     act_in[idx_ff] = 1'b1;
                     run_in[idx_ff] = 1'b0;
                     if (req_ff.req_type == cht_pkg::REQ_CREATE_ANY) begin
                        hold_rsp_in.channel_out = 5'({1'b0, idx_ff} + 1'b1);
                     end
                  end
               end
               cht_pkg::REQ_BAD: begin
                  hold_rsp_in.status = cht_pkg::ST_BAD_PARAM;
               end
               default: begin
                  if (!id_ok) begin
                     hold_rsp_in.status = cht_pkg::ST_BAD_ID;
                  end else if (!act_ff[idx_ff]) begin
                     hold_rsp_in.status = cht_pkg::ST_NOT_EXIST;
                  end else begin
                     case (req_ff.req_type)
                        cht_pkg::REQ_DELETE: act_in[idx_ff] = 1'b0;
                        cht_pkg::REQ_START: begin
                           run_in[idx_ff] = 1'b1;
                           if (e_attr) begin
                              wr_en   = 1'b1;
                              wr_data = {e_attr, e_reload, e_reload, 32'd0};
                           end
                        end
                        cht_pkg::REQ_STOP: run_in[idx_ff] = 1'b0;
                        default: begin
                           hold_rsp_in.running   = run_ff[idx_ff];
                           hold_rsp_in.time_left = 33'($signed(e_phase)) +
                                                   33'($signed(e_count));
                        end
                     endcase
                  end
               end
            endcase
            state_in = S_OUT;
         end
         S_SCAN: begin
            if (!rv_ff || !rsp_stall) begin
               if (act_ff[idx_ff]) begin
                  wr_en = 1'b1;
                  if (n_count < 0) begin
                     wr_data = {e_attr, e_reload, e_reload, n_phase};
                     if (run_ff[idx_ff] && nfire_ff < 5'(cht_pkg::MAX_RESULTS)) begin
                        if (hold_ff) begin
                           rsp_in = hold_rsp_ff;
                           rv_in  = 1'b1;
                        end
                        hold_rsp_in = '0;
                        hold_rsp_in.channel_out = 5'({1'b0, idx_ff} + 1'b1);
                        hold_rsp_in.fire_valid  = 1'b1;
                        hold_rsp_in.fire_arg    = arg_rd;
                        hold_in  = 1'b1;
                        nfire_in = nfire_ff + 1'b1;
                     end
                  end else begin
                     wr_data = {e_attr, n_count, e_reload, n_phase};
                  end
               end
               if ({1'b0, idx_ff} == (CW+1)'(NUM_CHANNELS - 1)) begin
                  state_in = S_OUT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SWAIT;
               end
            end
         end
         S_OUT: begin
            // final result of the request, the last held fire of a tick, or an empty tick summary
            if (!rv_ff || !rsp_stall) begin
               rsp_in = '0;
               if (hold_ff) begin
                  rsp_in = hold_rsp_ff;
               end
               rsp_in.last = 1'b1;
               rv_in    = 1'b1;
               hold_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff   <= '0;
         run_ff   <= '0;
         rv_ff    <= 1'b0;
         hold_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         run_ff   <= run_in;
         rv_ff    <= rv_in;
         hold_ff  <= hold_in;
      end
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      nfire_ff    <= nfire_in;
      rsp_ff      <= rsp_in;
      hold_rsp_ff <= hold_rsp_in;
   end
endmodule

### src/cyclic_handler_timer_table.sv
// kernel requests pass the read, ewait, exec and out states from accept to result; a tick
// walks every channel through swait and scan before out, and waits while the result side stalls
// one request is processed at a time while the next ones wait in the front queue; the tick
// walk reads the channel entry ram through its registered read port
// a tick holds each fire back until the next fire or the end of the scan so the final one carries last
// reset: synchronous active high, clears active/running bits and queues
module cyclic_handler_timer_table #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_req_type,
   input  logic [4:0]  req_channel_id,
   input  logic        req_attr_start,
   input  logic [30:0] req_period,
   input  logic [30:0] req_phase,
   input  logic [31:0] req_handler_arg,
   input  logic [15:0] req_tick_delta,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_channel_out,
   output logic        rsp_running,
   output logic [32:0] rsp_time_left,
   output logic        rsp_fire_valid,
   output logic [31:0] rsp_fire_arg,
   output logic        rsp_last
);
   cht_pkg::req_type_type in_req, q_req;
   cht_pkg::rsp_type      rsp;
   logic q_valid, q_take;

   assign in_req = '{req_type: req_req_type, channel_id: req_channel_id,
                     attr_start: req_attr_start, period: req_period,
                     phase: req_phase, handler_arg: req_handler_arg,
                     tick_delta: req_tick_delta};

   cht_front #(.DEPTH(2)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_stall(req_stall),
      .in_req(in_req), .out_valid(q_valid), .out_take(q_take), .out_req(q_req));

   cht_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_take(q_take),
      .in_req(q_req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp));

   assign rsp_status      = rsp.status;
   assign rsp_channel_out = rsp.channel_out;
   assign rsp_running     = rsp.running;
   assign rsp_time_left   = rsp.time_left;
   assign rsp_fire_valid  = rsp.fire_valid;
   assign rsp_fire_arg    = rsp.fire_arg;
   assign rsp_last        = rsp.last;
endmodule

### src/cht_checker.sv
`include "cyclic_handler_timer_table_defines.svh"

module cht_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [4:0]  rsp_channel_out,
   input logic        rsp_fire_valid,
   input logic [31:0] rsp_fire_arg,
   input logic        rsp_last
);
   `CHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped")
   `CHT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_status) && $stable(rsp_channel_out) && $stable(rsp_fire_arg) && $stable(rsp_last), "rsp changed")
   `CHT_ASSERT_IMPL(a_fire_ok, clock, reset, rsp_valid && rsp_fire_valid, rsp_status == cht_pkg::ST_OK, "fire status")
   `CHT_ASSERT_IMPL(a_fire_chan, clock, reset, rsp_valid && rsp_fire_valid, rsp_channel_out != 5'd0, "fire chan")
   `CHT_ASSERT_IMPL(a_arg_zero, clock, reset, rsp_valid && !rsp_fire_valid, rsp_fire_arg == 32'd0, "arg")
endmodule

bind cyclic_handler_timer_table cht_checker u_cht_checker (.*);

### tb/sv/cyclic_handler_timer_table_test.sv
`timescale 1ns / 100ps

module cyclic_handler_timer_table_test;

   localparam int NCH = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_req_type = cht_pkg::REQ_TICK;
   logic [4:0]  req_channel_id = '0;
   logic        req_attr_start = 1'b0;
   logic [30:0] req_period = '0;
   logic [30:0] req_phase = '0;
   logic [31:0] req_handler_arg = '0;
   logic [15:0] req_tick_delta = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [4:0]  rsp_channel_out;
   logic        rsp_running;
   logic [32:0] rsp_time_left;
   logic        rsp_fire_valid;
   logic [31:0] rsp_fire_arg;
   logic        rsp_last;

   cyclic_handler_timer_table #(.NUM_CHANNELS(NCH)) dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // timer table mirror
   bit               t_active [NCH];
   bit               t_running [NCH];
   bit               t_attr [NCH];
   longint           t_count [NCH];
   longint           t_reload [NCH];
   longint           t_phase [NCH];
   logic [31:0]      t_arg [NCH];

   cht_pkg::rsp_type pending_rsp [$];
   int               errors = 0;
   int               n_fires = 0;
   int               n_rsp = 0;
   bit               quiet = 1'b0;

   function automatic cht_pkg::rsp_type mk(logic [2:0] st, logic [4:0] ch = 0,
                                           logic run = 0, longint left = 0,
                                           logic fv = 0, logic [31:0] fa = 0,
                                           logic lst = 1);
      cht_pkg::rsp_type r;
      r.status = st;
      r.channel_out = ch;
      r.running = run;
      r.time_left = left[32:0];
      r.fire_valid = fv;
      r.fire_arg = fa;
      r.last = lst;
      return r;
   endfunction

   function automatic logic [2:0] table_create(int s, cht_pkg::req_type_type q);
      if (q.period == 0) return cht_pkg::ST_BAD_PARAM;
      t_attr[s] = q.attr_start;
      t_arg[s] = q.handler_arg;
      t_count[s] = q.period;
      t_reload[s] = q.period;
      t_phase[s] = q.phase;
      t_active[s] = 1'b1;
      t_running[s] = 1'b0;
      return cht_pkg::ST_OK;
   endfunction

   task automatic predict_timer(cht_pkg::req_type_type q);
      int s;
      int n;
      int i;
      logic [2:0] st;
      bit found;
      s = int'(q.channel_id) - 1;
      if (q.req_type == cht_pkg::REQ_TICK) begin
         n = 0;
         for (i = 0; i < NCH; i++) begin
            if (!t_active[i]) continue;
            if (t_phase[i] > 0) t_phase[i] -= q.tick_delta;
            else begin
               t_phase[i] = 0;
               t_count[i] -= q.tick_delta;
            end
            if (t_count[i] < 0) begin
               t_count[i] = t_reload[i];
               if (t_running[i] && n < cht_pkg::MAX_RESULTS) begin
                  pending_rsp.push_back(mk(cht_pkg::ST_OK, 5'(i + 1), 0, 0, 1, t_arg[i], 0));
                  n++;
               end
            end
         end
         if (n == 0) pending_rsp.push_back(mk(cht_pkg::ST_OK));
         else pending_rsp[$].last = 1'b1;
         n_fires += n;
         return;
      end
      if (q.req_type == cht_pkg::REQ_CREATE_ANY) begin
         found = 0;
         for (i = 0; i < NCH && !found; i++)
            if (!t_active[i]) begin
               found = 1;
               st = table_create(i, q);
               pending_rsp.push_back(mk(st, st == cht_pkg::ST_OK ? 5'(i + 1) : 5'd0));
            end
         if (!found) pending_rsp.push_back(mk(cht_pkg::ST_NO_ID));
         return;
      end
      if (q.req_type == cht_pkg::REQ_BAD) begin
         pending_rsp.push_back(mk(cht_pkg::ST_BAD_PARAM));
         return;
      end
      if (q.channel_id < 1 || q.channel_id > NCH) begin
         pending_rsp.push_back(mk(cht_pkg::ST_BAD_ID));
         return;
      end
      if (q.req_type == cht_pkg::REQ_CREATE) begin
         st = t_active[s] ? cht_pkg::ST_EXISTS : table_create(s, q);
         pending_rsp.push_back(mk(st));
         return;
      end
      if (!t_active[s]) begin
         pending_rsp.push_back(mk(cht_pkg::ST_NOT_EXIST));
         return;
      end
      case (q.req_type)
         cht_pkg::REQ_DELETE: t_active[s] = 1'b0;
         cht_pkg::REQ_START: begin
            t_running[s] = 1'b1;
            if (t_attr[s]) begin
               t_count[s] = t_reload[s];
               t_phase[s] = 0;
            end
         end
         cht_pkg::REQ_STOP: t_running[s] = 1'b0;
         default: begin
            pending_rsp.push_back(mk(cht_pkg::ST_OK, 0, t_running[s],
                                     t_phase[s] + t_count[s]));
            return;
         end
      endcase
      pending_rsp.push_back(mk(cht_pkg::ST_OK));
   endtask

   always @(posedge clock) begin
      cht_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); errors++;
            end
            if (rsp_channel_out !== e.channel_out) begin
               $error("channel_out exp %0d got %0d", e.channel_out, rsp_channel_out);
               errors++;
            end
            if (rsp_running !== e.running) begin
               $error("running exp %0d got %0d", e.running, rsp_running); errors++;
            end
            if (rsp_time_left !== e.time_left) begin
               $error("time_left exp %0h got %0h", e.time_left, rsp_time_left);
               errors++;
            end
            if (rsp_fire_valid !== e.fire_valid) begin
               $error("fire_valid exp %0d got %0d", e.fire_valid, rsp_fire_valid);
               errors++;
            end
            if (rsp_fire_arg !== e.fire_arg) begin
               $error("fire_arg exp %0h got %0h", e.fire_arg, rsp_fire_arg); errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last); errors++;
            end
         end
      end
   end

   // receiver stall bursts
   initial begin
      int k;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            k = $urandom_range(1, 15);
            repeat (k) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
      end
   end

   task automatic send_request(cht_pkg::req_type_type q);
      int k;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         k = $urandom_range(1, 15);
         repeat (k) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_req_type <= q.req_type;
      req_channel_id <= q.channel_id;
      req_attr_start <= q.attr_start;
      req_period <= q.period;
      req_phase <= q.phase;
      req_handler_arg <= q.handler_arg;
      req_tick_delta <= q.tick_delta;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_timer(q);
      @(negedge clock);
   endtask

   function automatic cht_pkg::req_type_type rq(logic [2:0] t, logic [4:0] id = 1,
                                                logic a = 0, logic [30:0] p = 5,
                                                logic [30:0] ph = 0,
                                                logic [31:0] arg = 0,
                                                logic [15:0] d = 0);
      cht_pkg::req_type_type q;
      q.req_type = t;
      q.channel_id = id;
      q.attr_start = a;
      q.period = p;
      q.phase = ph;
      q.handler_arg = arg;
      q.tick_delta = d;
      return q;
   endfunction

   function automatic cht_pkg::req_type_type rand_req(bit tidy);
      cht_pkg::req_type_type q;
      int pick;
      q = rq(cht_pkg::REQ_TICK);
      q.channel_id = tidy ? 5'($urandom_range(1, NCH)) : 5'($urandom_range(0, 31));
      q.attr_start = 1'($urandom_range(0, 1));
      q.handler_arg = $urandom;
      q.period = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40));
      q.phase = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 30));
      q.tick_delta = ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                     16'($urandom_range(0, 12));
      pick = $urandom_range(0, 99);
      if (pick < 15) q.req_type = cht_pkg::REQ_CREATE;
      else if (pick < 25) q.req_type = cht_pkg::REQ_CREATE_ANY;
      else if (pick < 32) q.req_type = cht_pkg::REQ_DELETE;
      else if (pick < 45) q.req_type = cht_pkg::REQ_START;
      else if (pick < 50) q.req_type = cht_pkg::REQ_STOP;
      else if (pick < 60) q.req_type = cht_pkg::REQ_QUERY;
      else if (pick < 98) q.req_type = cht_pkg::REQ_TICK;
      else q.req_type = cht_pkg::REQ_BAD;
      return q;
   endfunction

   typedef struct {
      cht_pkg::req_type_type q;
      bit                    typed;
      cht_pkg::rsp_type      r;
   } stim_row_type;

   stim_row_type directed [$];

   initial begin
      int i;
      stim_row_type row;
      directed = '{
         '{rq(cht_pkg::REQ_TICK, 0, 0, 0, 0, 0, 16'hffff), 1, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_QUERY, 1), 1, mk(cht_pkg::ST_NOT_EXIST)},
         '{rq(cht_pkg::REQ_CREATE, 0), 1, mk(cht_pkg::ST_BAD_ID)},
         '{rq(cht_pkg::REQ_CREATE, 17), 1, mk(cht_pkg::ST_BAD_ID)},
         '{rq(cht_pkg::REQ_START, 31), 1, mk(cht_pkg::ST_BAD_ID)},
         '{rq(cht_pkg::REQ_CREATE, 1, 0, 0), 1, mk(cht_pkg::ST_BAD_PARAM)},
         '{rq(cht_pkg::REQ_CREATE_ANY, 0, 0, 0), 1, mk(cht_pkg::ST_BAD_PARAM)},
         '{rq(cht_pkg::REQ_BAD, 3), 1, mk(cht_pkg::ST_BAD_PARAM)},
         '{rq(cht_pkg::REQ_CREATE, 16, 1, 31'h7fffffff, 31'h7fffffff, 32'hffffffff), 1,
           mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_CREATE, 16, 0, 3), 1, mk(cht_pkg::ST_EXISTS)},
         '{rq(cht_pkg::REQ_QUERY, 16), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_START, 16), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_CREATE_ANY, 0, 0, 2, 1, 32'ha5a5a5a5), 1, mk(cht_pkg::ST_OK, 1)},
         '{rq(cht_pkg::REQ_START, 1), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_TICK, 0, 0, 0, 0, 0, 3), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_QUERY, 1), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_TICK, 0, 0, 0, 0, 0, 3), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_STOP, 1), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_TICK, 0, 0, 0, 0, 0, 16'hffff), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_QUERY, 1), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_DELETE, 1), 0, mk(cht_pkg::ST_OK)},
         '{rq(cht_pkg::REQ_DELETE, 1), 1, mk(cht_pkg::ST_NOT_EXIST)},
         '{rq(cht_pkg::REQ_STOP, 16), 0, mk(cht_pkg::ST_OK)}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[k]) begin
         row = directed[k];
         send_request(row.q);
         if (row.typed && pending_rsp[$] != row.r) begin
            $error("table row %0d: typed response differs from mirror", k);
            errors++;
         end
      end
      // empty then fill the table, all running with short periods, to use every fire slot
      send_request(rq(cht_pkg::REQ_DELETE, 5'(NCH)));
      for (i = 0; i < NCH + 1; i++)
         send_request(rq(cht_pkg::REQ_CREATE_ANY, 0, 1, 31'(1 + i % 2), 0, $urandom));
      for (i = 1; i <= NCH; i++) send_request(rq(cht_pkg::REQ_START, 5'(i)));
      send_request(rq(cht_pkg::REQ_TICK, 0, 0, 0, 0, 0, 5));
      for (i = 1; i <= NCH; i++) send_request(rq(cht_pkg::REQ_DELETE, 5'(i)));
      for (i = 0; i < 356; i++) begin
         if (i >= 300) quiet = 1'b1;
         send_request(rand_req($urandom_range(0, 9) != 0));
      end
      req_valid <= 1'b0;
      quiet = 1'b1;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * NCH + 8) @(posedge clock);
      $display("covered all request kinds, id and parameter errors, full table");
      $display("responses checked %0d, fires seen %0d", n_rsp, n_fires);
      if (errors == 0) $display("cyclic_handler_timer_table_test passed");
      else $display("cyclic_handler_timer_table_test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("cyclic_handler_timer_table_test failed");
      $finish;
   end

endmodule
